// ===== rtl/light_bar_pair_matcher_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef LIGHT_BAR_PAIR_MATCHER_MACROS_SVH
`define LIGHT_BAR_PAIR_MATCHER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LBPM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LBPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lbpm_pkg.sv =====
package lbpm_pkg;

  localparam int HALF_TURN = 2880;
  localparam int FULL_TURN = 5760;

  localparam int ROOT_W = 17;   // floor sqrt of a 33 bit sum of squares
  localparam int RAD_W  = 34;   // radicand padded to whole bit pairs
  localparam int REM_W  = 20;

  typedef enum logic [2:0] {
    CFG_ANGLE_DIFF_LIMIT = 3'd0,
    CFG_RATIO_MIN        = 3'd1,
    CFG_RATIO_MAX        = 3'd2,
    CFG_BOX_ANGLE_MIN    = 3'd3,
    CFG_BOX_ANGLE_MAX    = 3'd4
  } cfg_idx_t;

  // Data that rides alongside the square root chain.
  typedef struct packed {
    logic        pass;   // the four pair tests held
    logic [15:0] cx;
    logic [15:0] cy;
    logic [16:0] hsum;   // sum of the two heights
    logic [12:0] s2;     // wrapped angle sum, two's complement
  } side_t;

endpackage

// ===== rtl/lbpm_front.sv =====
module lbpm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [15:0]         a_center_x,
  input  logic [15:0]         a_center_y,
  input  logic [15:0]         a_width,
  input  logic [15:0]         a_height,
  input  logic signed [11:0]  a_angle,
  input  logic [15:0]         b_center_x,
  input  logic [15:0]         b_center_y,
  input  logic [15:0]         b_width,
  input  logic [15:0]         b_height,
  input  logic signed [11:0]  b_angle,
  input  logic [11:0]         angle_lim,
  output logic                vld_o,
  output logic [lbpm_pkg::RAD_W-1:0] rad_o,
  output lbpm_pkg::side_t     side_o
);

  // stage A: pair tests and gaps
  logic signed [12:0] dsgn;
  logic [12:0]        dabs, dred;
  logic               ang_ok, hgt_ok, gap_x_ok, gap_y_ok;
  logic [15:0]        dx_c, dy_c;
  logic [16:0]        hsum_c, wsum_c, cxs, cys;
  logic signed [12:0] s2_raw, s2_c;
  lbpm_pkg::side_t    side_c;

  always_comb begin
    dsgn   = 13'(a_angle) - 13'(b_angle);
    dabs   = dsgn[12] ? 13'(-dsgn) : 13'(dsgn);
    dred   = (dabs > 13'(lbpm_pkg::HALF_TURN)) ? dabs - 13'(lbpm_pkg::HALF_TURN) : dabs;
    ang_ok = (dred < 13'(angle_lim)) ||
             ((13'(lbpm_pkg::HALF_TURN) - dred) < 13'(angle_lim));
    hgt_ok = ((19'(a_height) << 2) < 19'(b_height) * 19'd5 &&
              19'(a_height) * 19'd6 > 19'(b_height) * 19'd5) ||
             ((19'(b_height) << 2) < 19'(a_height) * 19'd5 &&
              19'(b_height) * 19'd6 > 19'(a_height) * 19'd5);
    dx_c     = (a_center_x > b_center_x) ? a_center_x - b_center_x : b_center_x - a_center_x;
    dy_c     = (a_center_y > b_center_y) ? a_center_y - b_center_y : b_center_y - a_center_y;
    wsum_c   = 17'(a_width) + 17'(b_width);
    hsum_c   = 17'(a_height) + 17'(b_height);
    gap_x_ok = 17'(dx_c) > wsum_c;
    gap_y_ok = {dy_c, 1'b0} < hsum_c;
    cxs      = 17'(a_center_x) + 17'(b_center_x);
    cys      = 17'(a_center_y) + 17'(b_center_y);
    s2_raw   = 13'(a_angle) + 13'(b_angle);
    if (s2_raw >= 13'sd2880) begin
      s2_c = s2_raw - 13'(lbpm_pkg::FULL_TURN);
    end else if (s2_raw < -13'sd2880) begin
      s2_c = s2_raw + 13'(lbpm_pkg::FULL_TURN);
    end else begin
      s2_c = s2_raw;
    end
    side_c.pass = ang_ok && hgt_ok && gap_x_ok && gap_y_ok;
    side_c.cx   = cxs[16:1];
    side_c.cy   = cys[16:1];
    side_c.hsum = hsum_c;
    side_c.s2   = s2_c;
  end

  logic            vld_a, vld_b;
  logic [15:0]     dx_a, dy_a;
  lbpm_pkg::side_t side_a, side_b;
  logic [31:0]     sqx_b, sqy_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_o <= 1'b0;
    end else if (adv) begin
      vld_a <= in_valid;
      vld_b <= vld_a;
      vld_o <= vld_b;
    end
  end

  // stage B squares, stage C sum
  always_ff @(posedge clk) begin
    if (adv) begin
      dx_a   <= dx_c;
      dy_a   <= dy_c;
      side_a <= side_c;
      sqx_b  <= dx_a * dx_a;
      sqy_b  <= dy_a * dy_a;
      side_b <= side_a;
      rad_o  <= {1'b0, 33'(sqx_b) + 33'(sqy_b)};
      side_o <= side_b;
    end
  end

endmodule

// ===== rtl/lbpm_sqrt_step.sv =====
module lbpm_sqrt_step #(
  parameter int STEP = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         vld_i,
  input  logic [lbpm_pkg::RAD_W-1:0]   rad_i,
  input  logic [lbpm_pkg::REM_W-1:0]   rem_i,
  input  logic [lbpm_pkg::ROOT_W-1:0]  root_i,
  input  lbpm_pkg::side_t              side_i,
  output logic                         vld_o,
  output logic [lbpm_pkg::RAD_W-1:0]   rad_o,
  output logic [lbpm_pkg::REM_W-1:0]   rem_o,
  output logic [lbpm_pkg::ROOT_W-1:0]  root_o,
  output lbpm_pkg::side_t              side_o
);

  // one root bit per step, pairs of radicand bits from the top
  logic [lbpm_pkg::REM_W-1:0] rem_sh, trial;
  logic                       ge;

  always_comb begin
    rem_sh = {rem_i[lbpm_pkg::REM_W-3:0], rad_i[2*STEP+1 -: 2]};
    trial  = lbpm_pkg::REM_W'({root_i, 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (adv) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_o  <= rad_i;
      rem_o  <= ge ? rem_sh - trial : rem_sh;
      root_o <= {root_i[lbpm_pkg::ROOT_W-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

// ===== rtl/lbpm_back.sv =====
module lbpm_back #(
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        vld_i,
  input  logic [lbpm_pkg::ROOT_W-1:0] root_i,
  input  lbpm_pkg::side_t             side_i,
  input  logic [11:0]                 ratio_min,
  input  logic [11:0]                 ratio_max,
  input  logic signed [11:0]          box_angle_min,
  input  logic signed [11:0]          box_angle_max,
  output logic                        vld_o,
  output logic                        is_armor,
  output logic [15:0]                 box_center_x,
  output logic [15:0]                 box_center_y,
  output logic [12:0]                 box_width,
  output logic [12:0]                 box_height,
  output logic signed [11:0]          box_angle
);

  logic [16:0] nl, nw, bwid_c, bhgt_c;

  always_comb begin
    nl     = side_i.hsum >> (COORD_FRAC_BITS + 1);
    nw     = root_i >> COORD_FRAC_BITS;
    bwid_c = (nl < nw) ? nw : nl;
    bhgt_c = (nl < nw) ? nl : nw;
  end

  // stage D: box sides and ratio products
  logic            vld_d;
  lbpm_pkg::side_t side_d;
  logic [16:0]     bwid_d, bhgt_d;
  logic [28:0]     pmin_d, pmax_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= 1'b0;
      vld_o <= 1'b0;
    end else if (adv) begin
      vld_d <= vld_i;
      vld_o <= vld_d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d <= side_i;
      bwid_d <= bwid_c;
      bhgt_d <= bhgt_c;
      pmin_d <= 29'(ratio_min) * 29'(bhgt_c);
      pmax_d <= 29'(ratio_max) * 29'(bhgt_c);
    end
  end

  // stage E: windows and result register
  logic [28:0]        bw256;
  logic signed [12:0] s2s;
  logic               ok;

  always_comb begin
    bw256 = 29'(bwid_d) << 8;
    s2s   = $signed(side_d.s2);
    ok    = side_d.pass && (bhgt_d != 17'd0) && (bw256 > pmin_d) && (bw256 < pmax_d) &&
            (14'(s2s) > (14'(box_angle_min) <<< 1)) &&
            (14'(s2s) < (14'(box_angle_max) <<< 1));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      is_armor     <= ok;
      box_center_x <= ok ? side_d.cx : 16'd0;
      box_center_y <= ok ? side_d.cy : 16'd0;
      box_width    <= ok ? bwid_d[12:0] : 13'd0;
      box_height   <= ok ? bhgt_d[12:0] : 13'd0;
      box_angle    <= ok ? 12'(s2s >>> 1) : 12'sd0;
    end
  end

endmodule

// ===== rtl/light_bar_pair_matcher.sv =====
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  a_* and b_* bar fields
// result    out        out_valid/out_stall is_armor, box_*
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One pair per cycle while the result output is not stalled.
// The square root chain computes one root bit per stage, 17 stages.
// rst is synchronous, active high, clears valid bits and restores the configuration registers to their defaults.
// The whole pipeline holds only while a result is shown and stalled; an empty
// result slot never holds it.
`include "light_bar_pair_matcher_macros.svh"

module light_bar_pair_matcher #(
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        a_center_x,
  input  logic [15:0]        a_center_y,
  input  logic [15:0]        a_width,
  input  logic [15:0]        a_height,
  input  logic signed [11:0] a_angle,
  input  logic [15:0]        b_center_x,
  input  logic [15:0]        b_center_y,
  input  logic [15:0]        b_width,
  input  logic [15:0]        b_height,
  input  logic signed [11:0] b_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_armor,
  output logic [15:0]        box_center_x,
  output logic [15:0]        box_center_y,
  output logic [12:0]        box_width,
  output logic [12:0]        box_height,
  output logic signed [11:0] box_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  localparam int NSTEP = lbpm_pkg::ROOT_W;

  // Pipeline advances unless the result register holds a stalled transaction.
  logic adv;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Configuration registers
  logic [11:0]        angle_diff_limit, ratio_min, ratio_max;
  logic signed [11:0] box_angle_min, box_angle_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_diff_limit <= 12'd160;
      ratio_min        <= 12'd256;
      ratio_max        <= 12'd1280;
      box_angle_min    <= -12'sd320;
      box_angle_max    <= 12'sd320;
    end else if (cfg_valid && cfg_ready) begin
      case (lbpm_pkg::cfg_idx_t'(cfg_index))
        lbpm_pkg::CFG_ANGLE_DIFF_LIMIT: angle_diff_limit <= cfg_data;
        lbpm_pkg::CFG_RATIO_MIN:        ratio_min        <= cfg_data;
        lbpm_pkg::CFG_RATIO_MAX:        ratio_max        <= cfg_data;
        lbpm_pkg::CFG_BOX_ANGLE_MIN:    box_angle_min    <= $signed(cfg_data);
        lbpm_pkg::CFG_BOX_ANGLE_MAX:    box_angle_max    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Front end: pair tests, squares, radicand (three stages)
  logic                        vld_s [NSTEP+1];
  logic [lbpm_pkg::RAD_W-1:0]  rad_s [NSTEP+1];
  logic [lbpm_pkg::REM_W-1:0]  rem_s [NSTEP+1];
  logic [lbpm_pkg::ROOT_W-1:0] root_s[NSTEP+1];
  lbpm_pkg::side_t             side_s[NSTEP+1];

  lbpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .a_center_x (a_center_x),
    .a_center_y (a_center_y),
    .a_width    (a_width),
    .a_height   (a_height),
    .a_angle    (a_angle),
    .b_center_x (b_center_x),
    .b_center_y (b_center_y),
    .b_width    (b_width),
    .b_height   (b_height),
    .b_angle    (b_angle),
    .angle_lim  (angle_diff_limit),
    .vld_o      (vld_s[0]),
    .rad_o      (rad_s[0]),
    .side_o     (side_s[0])
  );

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  // Square root chain, most significant bit pair first
  for (genvar i = 0; i < NSTEP; i++) begin : g_sqrt
    lbpm_sqrt_step #(.STEP(NSTEP-1-i)) u_step (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .vld_i  (vld_s[i]),
      .rad_i  (rad_s[i]),
      .rem_i  (rem_s[i]),
      .root_i (root_s[i]),
      .side_i (side_s[i]),
      .vld_o  (vld_s[i+1]),
      .rad_o  (rad_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .root_o (root_s[i+1]),
      .side_o (side_s[i+1])
    );
  end

  // Back end: box sides, ratio and angle windows, result register
  lbpm_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .vld_i         (vld_s[NSTEP]),
    .root_i        (root_s[NSTEP]),
    .side_i        (side_s[NSTEP]),
    .ratio_min     (ratio_min),
    .ratio_max     (ratio_max),
    .box_angle_min (box_angle_min),
    .box_angle_max (box_angle_max),
    .vld_o         (out_valid),
    .is_armor      (is_armor),
    .box_center_x  (box_center_x),
    .box_center_y  (box_center_y),
    .box_width     (box_width),
    .box_height    (box_height),
    .box_angle     (box_angle)
  );

  logic box_nonzero;
  assign box_nonzero = |{box_center_x, box_center_y, box_width, box_height, box_angle};

  // A rejected pair carries an all-zero box.
  `LBPM_ASSERT_IMPL(a_reject_zero, out_valid && !is_armor, !box_nonzero, "nonzero box on reject")
  // An accepted box has nonzero height.
  `LBPM_ASSERT_IMPL(a_accept_hgt, out_valid && is_armor, box_height != 13'd0, "zero box height")
  // A stalled result leaves the pipeline frozen, so the input side stalls too.
  `LBPM_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid, "stalled result lost")

endmodule
